### rtl/core/hft_pkg.sv
// ----------------------------------------------------------------------------
// hft_pkg
// Shared types and codes of the Huffman tree bit decoder.
// ----------------------------------------------------------------------------
package hft_pkg;

    localparam int SYM_W = 8;

    typedef enum logic [1:0] {
        OP_CODE_BIT = 2'd0,
        OP_CODE_END = 2'd1,
        OP_DATA_BIT = 2'd2,
        OP_CLEAR    = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_SECOND
    } phase_e;

    // Outcome of the first step of an item, used by the second step.
    typedef enum logic [2:0] {
        PATH_NONE,
        PATH_HIT,
        PATH_ALLOC,
        PATH_FULL,
        PATH_MISS
    } path_e;

    typedef struct packed {
        logic             symbol_valid;
        logic [SYM_W-1:0] decoded_symbol;
        status_e          status;
    } result_t;

endpackage

### rtl/core/hft_in_if.sv
// ----------------------------------------------------------------------------
// hft_in_if
// Input item channel: valid/ready handshake with operation, bit and symbol.
// ----------------------------------------------------------------------------
interface hft_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic                      bit_req;
    logic [hft_pkg::SYM_W-1:0] symbol;

    modport source (
        output valid,
        output operation,
        output bit_req,
        output symbol,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  bit_req,
        input  symbol,
        output ready
    );
endinterface

### rtl/core/hft_out_if.sv
// ----------------------------------------------------------------------------
// hft_out_if
// Result channel: valid/ready handshake with decoded symbol and status.
// ----------------------------------------------------------------------------
interface hft_out_if;
    logic                      valid;
    logic                      ready;
    logic                      symbol_valid;
    logic [hft_pkg::SYM_W-1:0] decoded_symbol;
    logic [1:0]                status;

    modport source (
        output valid,
        output symbol_valid,
        output decoded_symbol,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  symbol_valid,
        input  decoded_symbol,
        input  status,
        output ready
    );
endinterface

### rtl/core/hft_engine.sv
// ----------------------------------------------------------------------------
// hft_engine
// Node table memory and the two-step sequencer that builds and walks the tree.
// ----------------------------------------------------------------------------
module hft_engine #(
    parameter int MAX_NODES = 512
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  hft_pkg::op_e              item_op,
    input  logic                      item_bit,
    input  logic [hft_pkg::SYM_W-1:0] item_symbol,
    output logic                      res_valid,
    input  logic                      res_ready,
    output hft_pkg::result_t          res
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic [AW-1:0]             left;
        logic [AW-1:0]             right;
        logic                      leaf;
        logic [hft_pkg::SYM_W-1:0] sym;
    } node_t;

    localparam node_t EMPTY_NODE = '0;

    node_t mem [MAX_NODES];

    hft_pkg::phase_e phase_reg, phase_next;
    hft_pkg::op_e    op_reg;
    logic            dir_reg;
    logic [hft_pkg::SYM_W-1:0] sym_reg;

    hft_pkg::path_e  path_reg, path_next;
    logic [AW-1:0]   child_reg, child_next;
    node_t           rdata_reg;

    logic [AW-1:0]   build_ptr_reg, build_ptr_next;
    logic [AW-1:0]   dec_ptr_reg, dec_ptr_next;
    logic [CW-1:0]   next_free_reg, next_free_next;
    node_t           root_reg, root_next;
    node_t           bld_node_reg, bld_node_next;
    node_t           dec_node_reg, dec_node_next;

    logic            accept;
    logic            finish;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    node_t           mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [AW-1:0]   bld_child;
    logic [AW-1:0]   dec_child;
    logic            has_room;
    logic            leaf_hit;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            hft_pkg::PH_IDLE:
            begin
                if (item_valid)
                begin
                    phase_next = hft_pkg::PH_FIRST;
                end
            end
            hft_pkg::PH_FIRST:
            begin
                phase_next = hft_pkg::PH_SECOND;
            end
            hft_pkg::PH_SECOND:
            begin
                if (res_ready)
                begin
                    phase_next = item_valid ? hft_pkg::PH_FIRST : hft_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = hft_pkg::PH_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready = (phase_reg == hft_pkg::PH_IDLE) ||
                     ((phase_reg == hft_pkg::PH_SECOND) && res_ready);
        res_valid  = (phase_reg == hft_pkg::PH_SECOND);
        finish     = (phase_reg == hft_pkg::PH_SECOND) && res_ready;
    end

    assign accept = item_valid && item_ready;

    assign bld_child = dir_reg ? bld_node_reg.right : bld_node_reg.left;
    assign dec_child = dir_reg ? dec_node_reg.right : dec_node_reg.left;
    assign has_room  = (next_free_reg < CW'(MAX_NODES));
    assign leaf_hit  = (path_reg == hft_pkg::PATH_HIT) && rdata_reg.leaf;

    // ------------------------------------------------------------------
    // Memory accesses, pointer and cached node updates
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = EMPTY_NODE;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        path_next      = path_reg;
        child_next     = child_reg;
        build_ptr_next = build_ptr_reg;
        dec_ptr_next   = dec_ptr_reg;
        next_free_next = next_free_reg;
        root_next      = root_reg;
        bld_node_next  = bld_node_reg;
        dec_node_next  = dec_node_reg;

        if (phase_reg == hft_pkg::PH_FIRST)
        begin
            path_next = hft_pkg::PATH_NONE;
            unique case (op_reg)
                hft_pkg::OP_CODE_BIT:
                begin
                    if (bld_child != '0)
                    begin
                        path_next  = hft_pkg::PATH_HIT;
                        child_next = bld_child;
                        mem_re     = 1'b1;
                        mem_raddr  = bld_child;
                    end
                    else if (has_room)
                    begin
                        // Link the new child into the current build node now;
                        // the child itself is written in the second step.
                        path_next  = hft_pkg::PATH_ALLOC;
                        child_next = next_free_reg[AW-1:0];
                        mem_we     = 1'b1;
                        mem_waddr  = build_ptr_reg;
                        mem_wdata  = bld_node_reg;
                        if (dir_reg)
                        begin
                            mem_wdata.right = next_free_reg[AW-1:0];
                        end
                        else
                        begin
                            mem_wdata.left = next_free_reg[AW-1:0];
                        end
                    end
                    else
                    begin
                        path_next = hft_pkg::PATH_FULL;
                    end
                end
                hft_pkg::OP_CODE_END:
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = build_ptr_reg;
                    mem_wdata      = bld_node_reg;
                    mem_wdata.leaf = 1'b1;
                    mem_wdata.sym  = sym_reg;
                end
                hft_pkg::OP_DATA_BIT:
                begin
                    if (dec_child != '0)
                    begin
                        path_next  = hft_pkg::PATH_HIT;
                        child_next = dec_child;
                        mem_re     = 1'b1;
                        mem_raddr  = dec_child;
                    end
                    else
                    begin
                        path_next = hft_pkg::PATH_MISS;
                    end
                end
                hft_pkg::OP_CLEAR:
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = '0;
                    mem_wdata      = EMPTY_NODE;
                    next_free_next = CW'(1);
                    build_ptr_next = '0;
                    dec_ptr_next   = '0;
                end
                default:
                begin
                    path_next = hft_pkg::PATH_NONE;
                end
            endcase
        end
        else if (finish && (op_reg == hft_pkg::OP_CODE_BIT) &&
                 (path_reg == hft_pkg::PATH_ALLOC))
        begin
            mem_we         = 1'b1;
            mem_waddr      = child_reg;
            mem_wdata      = EMPTY_NODE;
            build_ptr_next = child_reg;
            next_free_next = next_free_reg + CW'(1);
        end

        // Keep the cached copies in step with every table write.
        if (mem_we && (mem_waddr == '0))
        begin
            root_next = mem_wdata;
        end
        if (mem_we && (mem_waddr == build_ptr_reg))
        begin
            bld_node_next = mem_wdata;
        end
        if (mem_we && (mem_waddr == dec_ptr_reg))
        begin
            dec_node_next = mem_wdata;
        end

        // Explicit reloads take priority over the write snooping above.
        if ((phase_reg == hft_pkg::PH_FIRST) && (op_reg == hft_pkg::OP_CLEAR))
        begin
            root_next     = EMPTY_NODE;
            bld_node_next = EMPTY_NODE;
            dec_node_next = EMPTY_NODE;
        end
        else if (finish)
        begin
            priority case (op_reg)
                hft_pkg::OP_CODE_BIT:
                begin
                    if (path_reg == hft_pkg::PATH_HIT)
                    begin
                        build_ptr_next = child_reg;
                        bld_node_next  = rdata_reg;
                    end
                    else if (path_reg == hft_pkg::PATH_ALLOC)
                    begin
                        bld_node_next = EMPTY_NODE;
                    end
                    else
                    begin
                        build_ptr_next = '0;
                        bld_node_next  = root_reg;
                    end
                end
                hft_pkg::OP_CODE_END:
                begin
                    build_ptr_next = '0;
                    bld_node_next  = root_reg;
                end
                hft_pkg::OP_DATA_BIT:
                begin
                    if ((path_reg == hft_pkg::PATH_HIT) && !rdata_reg.leaf)
                    begin
                        dec_ptr_next  = child_reg;
                        dec_node_next = rdata_reg;
                    end
                    else
                    begin
                        dec_ptr_next  = '0;
                        dec_node_next = root_reg;
                    end
                end
                default:
                begin
                    build_ptr_next = build_ptr_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result of the item in its second step
    // ------------------------------------------------------------------
    always_comb
    begin
        res.symbol_valid   = (op_reg == hft_pkg::OP_DATA_BIT) && leaf_hit;
        res.decoded_symbol = res.symbol_valid ? rdata_reg.sym : '0;
        if (path_reg == hft_pkg::PATH_FULL)
        begin
            res.status = hft_pkg::ST_FULL;
        end
        else if (path_reg == hft_pkg::PATH_MISS)
        begin
            res.status = hft_pkg::ST_MISSING;
        end
        else
        begin
            res.status = hft_pkg::ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hft_pkg::PH_IDLE;
            build_ptr_reg <= '0;
            dec_ptr_reg   <= '0;
            next_free_reg <= CW'(1);
            root_reg      <= EMPTY_NODE;
            bld_node_reg  <= EMPTY_NODE;
            dec_node_reg  <= EMPTY_NODE;
        end
        else
        begin
            phase_reg     <= phase_next;
            build_ptr_reg <= build_ptr_next;
            dec_ptr_reg   <= dec_ptr_next;
            next_free_reg <= next_free_next;
            root_reg      <= root_next;
            bld_node_reg  <= bld_node_next;
            dec_node_reg  <= dec_node_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= item_op;
            dir_reg <= item_bit;
            sym_reg <= item_symbol;
        end
        path_reg  <= path_next;
        child_reg <= child_next;
    end

    // Node table: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

### rtl/core/hft_result_reg.sv
// ----------------------------------------------------------------------------
// hft_result_reg
// Output register that holds one result until the result channel takes it.
// ----------------------------------------------------------------------------
module hft_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  hft_pkg::result_t res,
    hft_out_if.source        result
);

    logic             valid_reg;
    hft_pkg::result_t data_reg;

    assign res_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.symbol_valid   = data_reg.symbol_valid;
    assign result.decoded_symbol = data_reg.decoded_symbol;
    assign result.status         = data_reg.status;

endmodule

### rtl/core/huffman_tree_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit
// Huffman decoder that builds a code tree in a node table and walks it bit
// by bit, emitting one result per input transaction.
// ----------------------------------------------------------------------------
//  Channel   Modport   Payload                                  Per transaction
//  item      sink      operation[1:0], bit_req, symbol[7:0]     one tree op
//  result    source    symbol_valid, decoded_symbol[7:0],       one result
//                      status[1:0]
//
//  Every item passes through two steps: a first step that reads the chosen child
//  node from the node table (or writes the current node) and a second step that
//  uses the registered read data.
//  Reset brings the root back empty and both pointers to the root; no pass
//  over the table is needed, since nodes are initialized when allocated.
//  A result waiting in the output register blocks the next item only while the
//  result channel does not take it; that holds the sequencer in its second step.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_unit #(
    parameter int MAX_NODES = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    hft_in_if.sink    item,
    hft_out_if.source result
);

    logic             res_valid;
    logic             res_ready;
    hft_pkg::result_t res;

    hft_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_ready  (item.ready),
        .item_op     (hft_pkg::op_e'(item.operation)),
        .item_bit    (item.bit_req),
        .item_symbol (item.symbol),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    hft_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .result    (result)
    );

endmodule
